// File: rtl/vtu_pkg.sv
// Shared types and constants of the vertex transform unit.
package vtu_pkg;

   localparam int COORD_W = 32;   // Q16.16 point component
   localparam int COEF_W  = 24;   // lane coefficient, Q.16 fraction
   localparam int LANES   = 3;
   localparam int ADDR_W  = 6;
   localparam int DATA_W  = 64;

   typedef enum logic [1:0] {
      MODE_AFFINE = 2'd0,
      MODE_NORMAL = 2'd1,
      MODE_ROTATE = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      REG_MODE     = 3'd0,
      REG_COEFF_X  = 3'd1,
      REG_COEFF_Y  = 3'd2,
      REG_COEFF_Z  = 3'd3,
      REG_OFFSET_XY = 3'd4,
      REG_OFFSET_Z = 3'd5,
      REG_QUAT     = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_y;
      logic signed [COORD_W-1:0] in_z;
      logic                      batch_end;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      overflow;
      logic                      batch_end_out;
   } rsp_type;

   typedef struct packed {
      mode_type     transform_mode;
      logic [47:0]  coeffs_for_x;
      logic [47:0]  coeffs_for_y;
      logic [47:0]  coeffs_for_z;
      logic [63:0]  offset_xy;
      logic [31:0]  offset_z;
      logic [63:0]  rotation_quat;
   } cfg_type;

   // Coefficients of one output component: one per input component.
   typedef struct packed {
      logic signed [COEF_W-1:0]  c_x;
      logic signed [COEF_W-1:0]  c_y;
      logic signed [COEF_W-1:0]  c_z;
      logic signed [COORD_W-1:0] trans;
   } lane_coef_type;

   typedef lane_coef_type [LANES-1:0] coef_bus_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] value;
      logic                      ovf;
   } lane_out_type;

   typedef lane_out_type [LANES-1:0] lane_bus_type;

   typedef struct packed {
      logic valid;
      logic batch_end;
   } ctl_type;

endpackage

// File: rtl/vertex_transform_unit_top.sv
// Top level of the vertex transform unit: registers, coefficient builder, lanes.
//
// The unit takes one point per clock cycle and gives its transformed point from
// this chain of registers: an input register, a wait stage that lines
// the point up with the two-stage coefficient builder, three stages in each of
// the three component lanes (multiply, sum and round, translate and saturate)
// and the output register. The three lanes each hold three 32x24 multipliers
// and run side by side, so the sustained rate is one word per cycle; busy stays
// low. Each result word is shown for exactly one cycle on rsp_valid and cannot
// be held off. The user writes configuration only while no point is in flight;
// it is not enforced. A point may start in the cycle after the last write.
module vertex_transform_unit_top
   import vtu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int LANE_LAT = 3;

   cfg_type      cfg;
   coef_bus_type coef;
   lane_bus_type lane_res;
   logic         accept;
   logic         vld1_ff, vld2_ff;
   req_type      req1_ff, req2_ff;
   ctl_type      ctl_in;
   ctl_type [LANE_LAT-1:0] ctl_ff;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign accept = start && !busy;

   vtu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   vtu_coef u_coef (
      .clock (clock),
      .cfg   (cfg),
      .coef  (coef)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         ctl_ff  <= '0;
      end else begin
         vld1_ff <= accept;
         vld2_ff <= vld1_ff;
         ctl_ff  <= {ctl_ff[LANE_LAT-2:0], ctl_in};
      end
   end

   always_ff @(posedge clock) begin
      req1_ff <= req_data;
      req2_ff <= req1_ff;
   end

   assign ctl_in.valid     = vld2_ff;
   assign ctl_in.batch_end = req2_ff.batch_end;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      vtu_lane u_lane (
         .clock  (clock),
         .point  (req2_ff),
         .coef   (coef[i]),
         .result (lane_res[i])
      );
   end

   vtu_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lanes     (lane_res),
      .ctl       (ctl_ff[LANE_LAT-1]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A result word always follows an accepted point by the full latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_valid)
      else $error("result strobe missing after accepted point");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 6))
      else $error("result strobe without an accepted point");

   a_batch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.batch_end_out == $past(req_data.batch_end, 6)))
      else $error("batch marker out of step with its point");

   // Overflow is only flagged when some component sits at a saturation limit.
   a_ovf_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overflow) |->
         (rsp_data.out_x == 32'h7fffffff || rsp_data.out_x == 32'h80000000 ||
          rsp_data.out_y == 32'h7fffffff || rsp_data.out_y == 32'h80000000 ||
          rsp_data.out_z == 32'h7fffffff || rsp_data.out_z == 32'h80000000))
      else $error("overflow flag without a saturated component");

endmodule

// File: rtl/vtu_csr.sv
// Configuration register file behind the APB-style port.
module vtu_csr
   import vtu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   reg_index_type idx;
   logic          wr_en;

   assign idx   = reg_index_type'(paddr[ADDR_W-1:3]);
   assign wr_en = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.transform_mode <= MODE_AFFINE;
         cfg_ff.coeffs_for_x   <= 48'h0000_0000_1000;
         cfg_ff.coeffs_for_y   <= 48'h0000_1000_0000;
         cfg_ff.coeffs_for_z   <= 48'h1000_0000_0000;
         cfg_ff.offset_xy      <= '0;
         cfg_ff.offset_z       <= '0;
         cfg_ff.rotation_quat  <= 64'h4000_0000_0000_0000;
      end else if (wr_en) begin
         unique case (idx)
            REG_MODE: begin
               // The unused mode code leaves the register as it was.
               if (pwdata[1:0] != 2'd3) begin
                  cfg_ff.transform_mode <= mode_type'(pwdata[1:0]);
               end
            end
            REG_COEFF_X:   cfg_ff.coeffs_for_x  <= pwdata[47:0];
            REG_COEFF_Y:   cfg_ff.coeffs_for_y  <= pwdata[47:0];
            REG_COEFF_Z:   cfg_ff.coeffs_for_z  <= pwdata[47:0];
            REG_OFFSET_XY: cfg_ff.offset_xy     <= pwdata;
            REG_OFFSET_Z:  cfg_ff.offset_z      <= pwdata[31:0];
            REG_QUAT:      cfg_ff.rotation_quat <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_MODE:      prdata = {62'd0, cfg_ff.transform_mode};
         REG_COEFF_X:   prdata = {16'd0, cfg_ff.coeffs_for_x};
         REG_COEFF_Y:   prdata = {16'd0, cfg_ff.coeffs_for_y};
         REG_COEFF_Z:   prdata = {16'd0, cfg_ff.coeffs_for_z};
         REG_OFFSET_XY: prdata = cfg_ff.offset_xy;
         REG_OFFSET_Z:  prdata = {32'd0, cfg_ff.offset_z};
         REG_QUAT:      prdata = cfg_ff.rotation_quat;
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/vtu_coef.sv
// Builds the per-lane coefficient columns from the matrix or the quaternion.
module vtu_coef
   import vtu_pkg::*;
(
   input  logic         clock,
   input  cfg_type      cfg,
   output coef_bus_type coef
);

   localparam int DP_W  = 33;  // doubled quaternion product, Q.28
   localparam int ENT_W = 35;  // rotation entry before rounding, Q.28
   localparam logic signed [ENT_W-1:0] ONE_Q28 = ENT_W'(64'sd268435456);
   localparam logic signed [ENT_W-1:0] HALF_Q12 = ENT_W'(64'sd2048);

   logic signed [DP_W-1:0] xx_ff, xy_ff, xz_ff, yy_ff, yz_ff, zz_ff;
   logic signed [DP_W-1:0] wx_ff, wy_ff, wz_ff;
   logic signed [15:0]     qx, qy, qz, qw;
   coef_bus_type           coef_ff, coef_in;

   function automatic logic signed [DP_W-1:0] dprod(input logic signed [15:0] a,
                                                    input logic signed [15:0] b);
      logic signed [31:0] p;
      p = a * b;
      return {p, 1'b0};
   endfunction

   function automatic logic signed [ENT_W-1:0] ext(input logic signed [DP_W-1:0] v);
      return ENT_W'(v);
   endfunction

   // Round half up from Q.28 to Q.16.
   function automatic logic signed [COEF_W-1:0] rnd12(input logic signed [ENT_W-1:0] v);
      logic signed [ENT_W-1:0] t;
      t = v + HALF_Q12;
      return COEF_W'(t >>> 12);
   endfunction

   // Q4.12 matrix coefficient moved to the Q.16 lane format.
   function automatic logic signed [COEF_W-1:0] mcoef(input logic [15:0] v);
      return COEF_W'($signed({v, 4'b0000}));
   endfunction

   assign qx = $signed(cfg.rotation_quat[15:0]);
   assign qy = $signed(cfg.rotation_quat[31:16]);
   assign qz = $signed(cfg.rotation_quat[47:32]);
   assign qw = $signed(cfg.rotation_quat[63:48]);

   always_ff @(posedge clock) begin
      xx_ff <= dprod(qx, qx);
      xy_ff <= dprod(qx, qy);
      xz_ff <= dprod(qx, qz);
      yy_ff <= dprod(qy, qy);
      yz_ff <= dprod(qy, qz);
      zz_ff <= dprod(qz, qz);
      wx_ff <= dprod(qw, qx);
      wy_ff <= dprod(qw, qy);
      wz_ff <= dprod(qw, qz);
   end

   always_comb begin
      unique case (cfg.transform_mode)
         MODE_ROTATE: begin
            coef_in[0].c_x = rnd12(ONE_Q28 - ext(yy_ff) - ext(zz_ff));
            coef_in[0].c_y = rnd12(ext(xy_ff) - ext(wz_ff));
            coef_in[0].c_z = rnd12(ext(xz_ff) + ext(wy_ff));
            coef_in[1].c_x = rnd12(ext(xy_ff) + ext(wz_ff));
            coef_in[1].c_y = rnd12(ONE_Q28 - ext(xx_ff) - ext(zz_ff));
            coef_in[1].c_z = rnd12(ext(yz_ff) - ext(wx_ff));
            coef_in[2].c_x = rnd12(ext(xz_ff) - ext(wy_ff));
            coef_in[2].c_y = rnd12(ext(yz_ff) + ext(wx_ff));
            coef_in[2].c_z = rnd12(ONE_Q28 - ext(xx_ff) - ext(yy_ff));
            coef_in[0].trans = '0;
            coef_in[1].trans = '0;
            coef_in[2].trans = '0;
         end
         default: begin
            coef_in[0].c_x = mcoef(cfg.coeffs_for_x[15:0]);
            coef_in[0].c_y = mcoef(cfg.coeffs_for_x[31:16]);
            coef_in[0].c_z = mcoef(cfg.coeffs_for_x[47:32]);
            coef_in[1].c_x = mcoef(cfg.coeffs_for_y[15:0]);
            coef_in[1].c_y = mcoef(cfg.coeffs_for_y[31:16]);
            coef_in[1].c_z = mcoef(cfg.coeffs_for_y[47:32]);
            coef_in[2].c_x = mcoef(cfg.coeffs_for_z[15:0]);
            coef_in[2].c_y = mcoef(cfg.coeffs_for_z[31:16]);
            coef_in[2].c_z = mcoef(cfg.coeffs_for_z[47:32]);
            if (cfg.transform_mode == MODE_AFFINE) begin
               coef_in[0].trans = $signed(cfg.offset_xy[31:0]);
               coef_in[1].trans = $signed(cfg.offset_xy[63:32]);
               coef_in[2].trans = $signed(cfg.offset_z);
            end else begin
               coef_in[0].trans = '0;
               coef_in[1].trans = '0;
               coef_in[2].trans = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   assign coef = coef_ff;

endmodule

// File: rtl/vtu_lane.sv
// One output component: multiply, sum and round, translate and saturate.
module vtu_lane
   import vtu_pkg::*;
(
   input  logic          clock,
   input  req_type       point,
   input  lane_coef_type coef,
   output lane_out_type  result
);

   localparam int PROD_W = COORD_W + COEF_W;   // Q.32 product
   localparam int ACC_W  = PROD_W + 2;
   localparam int RND_W  = ACC_W - 16;
   localparam int RES_W  = RND_W + 1;
   localparam logic signed [ACC_W-1:0] HALF_Q16 = ACC_W'(64'sd32768);
   localparam logic signed [RES_W-1:0] MAX_V = RES_W'(64'sd2147483647);
   localparam logic signed [RES_W-1:0] MIN_V = RES_W'(-64'sd2147483648);

   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [ACC_W-1:0]  sum_in;
   logic signed [RND_W-1:0]  rnd_ff;
   logic signed [RES_W-1:0]  tot_in;
   lane_out_type             res_ff, res_in;

   always_ff @(posedge clock) begin
      px_ff <= PROD_W'(point.in_x) * PROD_W'(coef.c_x);
      py_ff <= PROD_W'(point.in_y) * PROD_W'(coef.c_y);
      pz_ff <= PROD_W'(point.in_z) * PROD_W'(coef.c_z);
   end

   assign sum_in = ACC_W'(px_ff) + ACC_W'(py_ff) + ACC_W'(pz_ff) + HALF_Q16;

   always_ff @(posedge clock) begin
      rnd_ff <= RND_W'(sum_in >>> 16);
   end

   // The translation is zero outside affine mode.
   assign tot_in = RES_W'(rnd_ff) + RES_W'(coef.trans);

   always_comb begin
      if (tot_in > MAX_V) begin
         res_in.value = COORD_W'(MAX_V);
         res_in.ovf   = 1'b1;
      end else if (tot_in < MIN_V) begin
         res_in.value = COORD_W'(MIN_V);
         res_in.ovf   = 1'b1;
      end else begin
         res_in.value = COORD_W'(tot_in);
         res_in.ovf   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

// File: rtl/vtu_merge.sv
// Joins the three lane results into one result word and drives the strobe.
module vtu_merge
   import vtu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  lane_bus_type lanes,
   input  ctl_type      ctl,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   logic    valid_ff;
   rsp_type data_ff, data_in;

   always_comb begin
      data_in.out_x         = lanes[0].value;
      data_in.out_y         = lanes[1].value;
      data_in.out_z         = lanes[2].value;
      data_in.overflow      = lanes[0].ovf | lanes[1].ovf | lanes[2].ovf;
      data_in.batch_end_out = ctl.batch_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the vertex transform unit: APB setup, point stream, result check.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import vtu_pkg::*;

   localparam int PHASES        = 9;
   localparam int PHASE_POINTS  = 214;
   localparam int SETTLE_CYCLES = 12;
   localparam int QUIET_LIMIT   = 2000;
   localparam logic [1:0] MODE_RESERVED = 2'd3;
   localparam logic [2:0] REG_UNUSED    = 3'd7;
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   logic              clock   = 1'b0;
   logic              reset   = 1'b1;
   logic              start   = 1'b0;
   logic              busy;
   req_type           req_data = '0;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [ADDR_W-1:0] paddr   = '0;
   logic [DATA_W-1:0] pwdata  = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // Register copies used by the predictor.
   mode_type    cur_mode = MODE_AFFINE;
   logic [47:0] cur_cx   = 48'h0000_0000_1000;
   logic [47:0] cur_cy   = 48'h0000_1000_0000;
   logic [47:0] cur_cz   = 48'h1000_0000_0000;
   logic [63:0] cur_oxy  = '0;
   logic [31:0] cur_oz   = '0;
   logic [63:0] cur_quat = 64'h4000_0000_0000_0000;

   req_type point_q[$];
   rsp_type transformed_q[$];
   int      send_idle_pct = 0;
   int      errors = 0;
   int      quiet = 0;

   always #6 clock = ~clock;

   vertex_transform_unit_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   function automatic longint lane16(logic [63:0] word, int i);
      logic signed [15:0] f;
      f = word[16*i +: 16];
      return longint'(f);
   endfunction

   function automatic longint round_half_up(longint v, int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
   endfunction

   function automatic rsp_type transform_point(req_type pt);
      longint p [3];
      longint t [3];
      longint m [3][3];
      logic [47:0] col [3];
      longint qx, qy, qz, qw, xx, xy, xz, yy, yz, zz, wx, wy, wz, one, acc, res;
      logic [31:0] comp [3];
      logic ovf;
      rsp_type r;
      p[0] = longint'(signed'(pt.in_x));
      p[1] = longint'(signed'(pt.in_y));
      p[2] = longint'(signed'(pt.in_z));
      col[0] = cur_cx;
      col[1] = cur_cy;
      col[2] = cur_cz;
      t[0] = longint'(signed'(cur_oxy[31:0]));
      t[1] = longint'(signed'(cur_oxy[63:32]));
      t[2] = longint'(signed'(cur_oz));
      qx = lane16(cur_quat, 0);
      qy = lane16(cur_quat, 1);
      qz = lane16(cur_quat, 2);
      qw = lane16(cur_quat, 3);
      xx = 2 * qx * qx; xy = 2 * qx * qy; xz = 2 * qx * qz;
      yy = 2 * qy * qy; yz = 2 * qy * qz; zz = 2 * qz * qz;
      wx = 2 * qw * qx; wy = 2 * qw * qy; wz = 2 * qw * qz;
      one = longint'(1) << 28;
      // Row selects the input component, column the output component.
      m[0][0] = one - yy - zz; m[1][0] = xy - wz;       m[2][0] = xz + wy;
      m[0][1] = xy + wz;       m[1][1] = one - xx - zz; m[2][1] = yz - wx;
      m[0][2] = xz - wy;       m[1][2] = yz + wx;       m[2][2] = one - xx - yy;
      ovf = 1'b0;
      for (int c = 0; c < 3; c++) begin
         acc = 0;
         if (cur_mode == MODE_ROTATE) begin
            for (int k = 0; k < 3; k++)
               acc += p[k] * round_half_up(m[k][c], 12);
            res = round_half_up(acc, 16);
         end else begin
            for (int k = 0; k < 3; k++)
               acc += p[k] * lane16(col[c], k);
            res = round_half_up(acc, 12);
            if (cur_mode == MODE_AFFINE)
               res += t[c];
         end
         if (res > Q_MAX) begin
            res = Q_MAX;
            ovf = 1'b1;
         end else if (res < Q_MIN) begin
            res = Q_MIN;
            ovf = 1'b1;
         end
         comp[c] = res[31:0];
      end
      r.out_x = comp[0];
      r.out_y = comp[1];
      r.out_z = comp[2];
      r.overflow = ovf;
      r.batch_end_out = pt.batch_end;
      return r;
   endfunction

   function automatic void apply_reg_write(logic [2:0] idx, logic [63:0] v);
      case (idx)
         REG_MODE:      if (v[1:0] != MODE_RESERVED) cur_mode = mode_type'(v[1:0]);
         REG_COEFF_X:   cur_cx = v[47:0];
         REG_COEFF_Y:   cur_cy = v[47:0];
         REG_COEFF_Z:   cur_cz = v[47:0];
         REG_OFFSET_XY: cur_oxy = v;
         REG_OFFSET_Z:  cur_oz = v[31:0];
         REG_QUAT:      cur_quat = v;
         default: ;
      endcase
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [63:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      apply_reg_write(idx, value);
   endtask

   task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
      req_type pt;
      pt.in_x = x;
      pt.in_y = y;
      pt.in_z = z;
      pt.batch_end = last;
      point_q.push_back(pt);
   endtask

   // Waits until every queued point is accepted and its word has come back.
   task automatic drain();
      while (point_q.size() != 0 || start || transformed_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0, 1: return 32'($urandom_range(32'h00FF_FFFF)) - 32'h0080_0000;
         2: return $urandom;
         default: begin
            case ($urandom_range(4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0001_0000;
            endcase
         end
      endcase
   endfunction

   function automatic logic [15:0] rand_coef();
      case ($urandom_range(3))
         0, 1: return 16'($urandom_range(16'h3000)) - 16'h1800;
         2: return 16'($urandom);
         default: begin
            case ($urandom_range(3))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               default: return 16'h1000;
            endcase
         end
      endcase
   endfunction

   function automatic logic [31:0] rand_offset();
      case ($urandom_range(3))
         0, 1: return 32'($urandom_range(32'h001F_FFFF)) - 32'h0010_0000;
         2: return $urandom;
         default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   function automatic logic [15:0] rand_quat_part();
      if ($urandom_range(3) == 0)
         return 16'($urandom);
      return 16'($urandom_range(16'h8000)) - 16'h4000;
   endfunction

   // Driver: keeps the current word on the bus until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            transformed_q.push_back(transform_point(req_data));
         if (!start || !busy) begin
            if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               start    <= 1'b1;
               req_data <= point_q.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic report_field(string name, longint want, longint got);
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
   endtask

   // Monitor: every word on the result port is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (transformed_q.size() == 0) begin
            $display("%0t ns: unexpected result word %h", $time, rsp_data);
            errors++;
         end else begin
            automatic rsp_type want = transformed_q.pop_front();
            if (rsp_data.out_x !== want.out_x)
               report_field("out_x", want.out_x, rsp_data.out_x);
            if (rsp_data.out_y !== want.out_y)
               report_field("out_y", want.out_y, rsp_data.out_y);
            if (rsp_data.out_z !== want.out_z)
               report_field("out_z", want.out_z, rsp_data.out_z);
            if (rsp_data.overflow !== want.overflow)
               report_field("overflow", want.overflow, rsp_data.overflow);
            if (rsp_data.batch_end_out !== want.batch_end_out)
               report_field("batch_end_out", want.batch_end_out, rsp_data.batch_end_out);
         end
      end
   end

   // Watchdog: counts cycles in which no word moves on any port.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pwrite && pready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("vertex_transform_unit_top: mismatch");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset state is the identity with no translation.
      add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      add_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
      add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
      drain();

      // Extreme coefficients and translations in affine mode.
      csr_write(REG_MODE, MODE_AFFINE);
      csr_write(REG_COEFF_X, 64'h0000_7FFF_8000_0001);
      csr_write(REG_COEFF_Y, 64'h0000_8000_7FFF_FFFF);
      csr_write(REG_COEFF_Z, 64'h0000_0800_F800_0003);
      csr_write(REG_OFFSET_XY, 64'h7FFF_FFFF_8000_0000);
      csr_write(REG_OFFSET_Z, 64'h0000_0000_0001_8000);
      csr_write(REG_QUAT, 64'h7FFF_8000_7FFF_8000);
      add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      add_point(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 1'b0);
      add_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, 1'b0);
      add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
      add_point(32'hFFF0_0000, 32'h0010_0000, 32'h0000_0800, 1'b0);
      drain();

      // Normal mode ignores the translation; a reserved mode write leaves it in place,
      // and so does a write past the last register.
      csr_write(REG_MODE, MODE_NORMAL);
      csr_write(REG_MODE, MODE_RESERVED);
      csr_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
      add_point(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 1'b0);
      add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      add_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, 1'b0);
      drain();

      // Rotation with a far from unit quaternion, then a quarter turn about z.
      csr_write(REG_MODE, MODE_ROTATE);
      add_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1);
      add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      drain();
      csr_write(REG_QUAT, {16'd11585, 16'd11585, 16'd0, 16'd0});
      add_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_point(32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 1'b1);
      add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case ((ph / 3) % 3)
            0: send_idle_pct = 0;
            1: send_idle_pct = 74;
            default: send_idle_pct = 26;
         endcase
         csr_write(REG_MODE, 64'(ph % 3));
         if ($urandom_range(3) == 0)
            csr_write(REG_MODE, MODE_RESERVED);
         csr_write(REG_COEFF_X, {16'($urandom), rand_coef(), rand_coef(), rand_coef()});
         csr_write(REG_COEFF_Y, {16'($urandom), rand_coef(), rand_coef(), rand_coef()});
         csr_write(REG_COEFF_Z, {16'($urandom), rand_coef(), rand_coef(), rand_coef()});
         csr_write(REG_OFFSET_XY, {rand_offset(), rand_offset()});
         csr_write(REG_OFFSET_Z, {32'($urandom), rand_offset()});
         csr_write(REG_QUAT, {rand_quat_part(), rand_quat_part(), rand_quat_part(),
                              rand_quat_part()});
         if ($urandom_range(3) == 0)
            csr_write(REG_UNUSED, {32'($urandom), 32'($urandom)});
         for (int n = 0; n < PHASE_POINTS; n++)
            add_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(1)));
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("vertex_transform_unit_top: match");
      end else begin
         $display("vertex_transform_unit_top: mismatch");
      end
      $finish;
   end

endmodule
